@@ hw/rtl/brb_pkg.sv @@
// shared constants, types and codes of the byte ring buffer
package brb_pkg;

	// store geometry
	localparam int BUF_DEPTH = 4096;
	localparam int MAX_PEEK  = 64;

	// field widths
	localparam int MODE_W = 3;
	localparam int LEN_W  = 13;
	localparam int OFF_W  = 12;
	localparam int DATA_W = 8;
	localparam int CFG_W  = 13;
	localparam int OUT_W  = 13;

	// derived widths
	localparam int ADDR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int SIZE_W     = $clog2(BUF_DEPTH + 1);
	localparam int SUM_W      = ((SIZE_W > LEN_W) ? SIZE_W : LEN_W) + 1;
	localparam int DIV_CNT_W  = $clog2(OFF_W + 1);
	localparam int PEEK_CNT_W = $clog2(MAX_PEEK + 1);

	// size after reset
	localparam int SIZE_RST = (BUF_DEPTH < 4096) ? BUF_DEPTH : 4096;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_STATUS  = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_STORE   = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_COMMIT  = MODE_W'(2);
	localparam logic [MODE_W-1:0] MODE_RELEASE = MODE_W'(3);
	localparam logic [MODE_W-1:0] MODE_PEEK    = MODE_W'(4);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_STORE,
		S_EMIT,
		S_PEEK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic apply_commit;
		logic apply_release;
		logic set_ok;
		logic ok_val;
		logic div_start;
		logic div_step;
		logic store_write;
		logic peek_first;
		logic peek_emit;
		logic status_emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              commit_fit;
		logic              release_fit;
		logic              peek_fit;
		logic              peek_zero;
		logic              div_done;
		logic              slot_free;
		logic              peek_last;
	} dp_stat_t;

endpackage

@@ hw/rtl/brb_cmd_if.sv @@
// command channel of the byte ring buffer
interface brb_cmd_if;
	import brb_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [LEN_W-1:0]  length;
	logic [OFF_W-1:0]  offset;
	logic [DATA_W-1:0] data_byte;

	modport source (output valid, mode, length, offset, data_byte, input ready);
	modport sink (input valid, mode, length, offset, data_byte, output ready);
endinterface

@@ hw/rtl/brb_rsp_if.sv @@
// result channel of the byte ring buffer
interface brb_rsp_if;
	import brb_pkg::*;

	logic              valid;
	logic              ready;
	logic [OUT_W-1:0]  write_space;
	logic [OUT_W-1:0]  tail_data;
	logic [OUT_W-1:0]  data_count;
	logic              ok;
	logic [DATA_W-1:0] peek_byte;
	logic              last;

	modport source (output valid, write_space, tail_data, data_count, ok, peek_byte, last,
		input ready);
	modport sink (input valid, write_space, tail_data, data_count, ok, peek_byte, last,
		output ready);
endinterface

@@ hw/rtl/brb_ram.sv @@
// generic single port ram with registered read
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule

@@ hw/rtl/brb_ctrl.sv @@
// controller state machine of the byte ring buffer
module brb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  brb_pkg::dp_stat_t   stat,
	output brb_pkg::ctrl_cmd_t  ctl
);
	import brb_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				case (stat.mode)
					MODE_STORE: state_nxt = S_DIV;
					MODE_PEEK: begin
						if (stat.peek_fit && !stat.peek_zero) begin
							state_nxt = S_PEEK;
						end else begin
							state_nxt = S_EMIT;
						end
					end
					default: state_nxt = S_EMIT;
				endcase
			end
			S_DIV: begin
				if (stat.div_done) state_nxt = S_STORE;
			end
			S_STORE: state_nxt = S_EMIT;
			S_EMIT: begin
				if (stat.slot_free) state_nxt = S_IDLE;
			end
			S_PEEK: begin
				if (stat.slot_free && stat.peek_last) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_ready     = 1'b1;
				ctl.load_item = cmd_valid;
			end
			S_EXEC: begin
				case (stat.mode)
					MODE_STATUS: begin
						ctl.set_ok = 1'b1;
						ctl.ok_val = 1'b1;
					end
					MODE_STORE: ctl.div_start = 1'b1;
					MODE_COMMIT: begin
						ctl.apply_commit = stat.commit_fit;
						ctl.set_ok       = 1'b1;
						ctl.ok_val       = stat.commit_fit;
					end
					MODE_RELEASE: begin
						ctl.apply_release = stat.release_fit;
						ctl.set_ok        = 1'b1;
						ctl.ok_val        = stat.release_fit;
					end
					MODE_PEEK: begin
						// refused or empty peeks leave a single status result
						ctl.set_ok     = 1'b1;
						ctl.ok_val     = stat.peek_fit;
						ctl.peek_first = stat.peek_fit && !stat.peek_zero;
					end
					default: begin
						ctl.set_ok = 1'b1;
						ctl.ok_val = 1'b0;
					end
				endcase
			end
			S_DIV: ctl.div_step = 1'b1;
			S_STORE: begin
				ctl.store_write = 1'b1;
				ctl.set_ok      = 1'b1;
				ctl.ok_val      = 1'b1;
			end
			S_EMIT: ctl.status_emit = stat.slot_free;
			S_PEEK: ctl.peek_emit = stat.slot_free;
			default: ;
		endcase
	end
endmodule

@@ hw/rtl/brb_dpath.sv @@
// datapath of the byte ring buffer: indices, remainder unit, store and result register
module brb_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [brb_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic [brb_pkg::MODE_W-1:0]  cmd_mode,
	input  logic [brb_pkg::LEN_W-1:0]   cmd_length,
	input  logic [brb_pkg::OFF_W-1:0]   cmd_offset,
	input  logic [brb_pkg::DATA_W-1:0]  cmd_data_byte,
	input  brb_pkg::ctrl_cmd_t          ctl,
	output brb_pkg::dp_stat_t           stat,
	input  logic                        rsp_ready,
	output logic                        rsp_valid,
	output logic [brb_pkg::OUT_W-1:0]   rsp_write_space,
	output logic [brb_pkg::OUT_W-1:0]   rsp_tail_data,
	output logic [brb_pkg::OUT_W-1:0]   rsp_data_count,
	output logic                        rsp_ok,
	output logic [brb_pkg::DATA_W-1:0]  rsp_peek_byte,
	output logic                        rsp_last
);
	import brb_pkg::*;

	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(BUF_DEPTH);
	localparam logic [SUM_W-1:0] PEEK_S  = SUM_W'(MAX_PEEK);
	localparam logic [SUM_W-1:0] ONE_S   = SUM_W'(1);

	// buffer state
	logic [SIZE_W-1:0] bs_q;
	logic [ADDR_W-1:0] ri_q;
	logic [ADDR_W-1:0] wi_q;
	logic [SIZE_W-1:0] held_q;

	// latched item
	logic [MODE_W-1:0] mode_q;
	logic [LEN_W-1:0]  len_q;
	logic [OFF_W-1:0]  off_q;
	logic [DATA_W-1:0] db_q;
	logic              ok_q;

	// remainder unit
	logic [SIZE_W-1:0]    rem_q;
	logic [OFF_W-1:0]     offsh_q;
	logic [DIV_CNT_W-1:0] dcnt_q;

	// peek walk
	logic [ADDR_W-1:0]     pk_addr_q;
	logic [PEEK_CNT_W-1:0] pk_cnt_q;

	// result register
	logic              rsp_valid_q;
	logic [OUT_W-1:0]  space_q;
	logic [OUT_W-1:0]  tail_q;
	logic [OUT_W-1:0]  count_q;
	logic              rok_q;
	logic [DATA_W-1:0] pbyte_q;
	logic              last_q;

	logic [SUM_W-1:0]  bs_x, ri_x, wi_x, held_x, len_x;
	logic [SUM_W-1:0]  cfg_x, cfg_clamp;
	logic [SUM_W-1:0]  wi_sum, ri_sum, st_sum, pk_inc, diff_x;
	logic [ADDR_W-1:0] wi_next, ri_next, st_addr, pk_next;
	logic [SIZE_W:0]   rem_sh;
	logic [SUM_W-1:0]  space_x, tail_x;
	logic              slot_free, peek_last, full;
	logic              ram_en;
	logic [ADDR_W-1:0] ram_addr;
	logic [DATA_W-1:0] ram_rdata;

	assign bs_x   = SUM_W'(bs_q);
	assign ri_x   = SUM_W'(ri_q);
	assign wi_x   = SUM_W'(wi_q);
	assign held_x = SUM_W'(held_q);
	assign len_x  = SUM_W'(len_q);

	// size register clamped to 1 .. depth
	assign cfg_x     = SUM_W'(cfg_wr_data);
	assign cfg_clamp = (cfg_x == '0) ? ONE_S : ((cfg_x > DEPTH_S) ? DEPTH_S : cfg_x);

	// commit and release arithmetic
	assign wi_sum  = wi_x + len_x;
	assign wi_next = (wi_sum == bs_x) ? '0 : ADDR_W'(wi_sum);
	assign ri_sum  = ri_x + len_x;
	assign ri_next = (ri_sum >= bs_x) ? ADDR_W'(ri_sum - bs_x) : ADDR_W'(ri_sum);

	// one restoring remainder step per cycle
	assign rem_sh = {rem_q, offsh_q[OFF_W-1]};

	// store address, both terms below the size
	assign st_sum  = wi_x + SUM_W'(rem_q);
	assign st_addr = (st_sum >= bs_x) ? ADDR_W'(st_sum - bs_x) : ADDR_W'(st_sum);

	assign pk_inc  = SUM_W'(pk_addr_q) + ONE_S;
	assign pk_next = (pk_inc == bs_x) ? '0 : ADDR_W'(pk_inc);

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign peek_last = (SUM_W'(pk_cnt_q) + ONE_S) == len_x;

	// status of the current state
	assign full   = (wi_q == ri_q) && (held_q != '0);
	assign diff_x = ri_x - wi_x;
	always_comb begin
		if (wi_q >= ri_q) begin
			space_x = full ? '0 : (bs_x - wi_x);
		end else begin
			space_x = (diff_x <= ONE_S) ? '0 : (diff_x - ONE_S);
		end
		tail_x = ((wi_q < ri_q) || full) ? (bs_x - ri_x) : held_x;
	end

	always_comb begin
		stat             = '0;
		stat.mode        = mode_q;
		stat.commit_fit  = ((held_x + len_x) <= bs_x) && (wi_sum <= bs_x);
		stat.release_fit = len_x <= held_x;
		stat.peek_fit    = (len_x <= PEEK_S) && (len_x <= held_x);
		stat.peek_zero   = len_q == '0;
		stat.div_done    = dcnt_q == DIV_CNT_W'(1);
		stat.slot_free   = slot_free;
		stat.peek_last   = peek_last;
	end

	// buffer state, cleared by reset and by a size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= SIZE_W'(SIZE_RST);
			ri_q   <= '0;
			wi_q   <= '0;
			held_q <= '0;
		end else if (cfg_wr_en) begin
			bs_q   <= SIZE_W'(cfg_clamp);
			ri_q   <= '0;
			wi_q   <= '0;
			held_q <= '0;
		end else begin
			if (ctl.apply_commit) begin
				wi_q   <= wi_next;
				held_q <= SIZE_W'(held_x + len_x);
			end
			if (ctl.apply_release) begin
				ri_q   <= ri_next;
				held_q <= SIZE_W'(held_x - len_x);
			end
		end
	end

	// item, remainder and peek registers
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			mode_q <= cmd_mode;
			len_q  <= cmd_length;
			off_q  <= cmd_offset;
			db_q   <= cmd_data_byte;
		end
		if (ctl.set_ok) ok_q <= ctl.ok_val;
		if (ctl.div_start) begin
			rem_q   <= '0;
			offsh_q <= off_q;
			dcnt_q  <= DIV_CNT_W'(OFF_W);
		end else if (ctl.div_step) begin
			rem_q   <= (rem_sh >= (SIZE_W+1)'(bs_q)) ? SIZE_W'(rem_sh - (SIZE_W+1)'(bs_q))
				: SIZE_W'(rem_sh);
			offsh_q <= offsh_q << 1;
			dcnt_q  <= dcnt_q - DIV_CNT_W'(1);
		end
		if (ctl.peek_first) begin
			pk_addr_q <= ri_q;
			pk_cnt_q  <= '0;
		end else if (ctl.peek_emit) begin
			pk_addr_q <= pk_next;
			pk_cnt_q  <= pk_cnt_q + PEEK_CNT_W'(1);
		end
	end

	// byte store; next peek read goes out as the current byte is emitted
	assign ram_en = ctl.store_write || ctl.peek_first || (ctl.peek_emit && !peek_last);
	always_comb begin
		if (ctl.store_write) begin
			ram_addr = st_addr;
		end else if (ctl.peek_first) begin
			ram_addr = ri_q;
		end else begin
			ram_addr = pk_next;
		end
	end

	brb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (BUF_DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ctl.store_write),
		.addr  (ram_addr),
		.wdata (db_q),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.status_emit || ctl.peek_emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.status_emit || ctl.peek_emit) begin
			space_q <= OUT_W'(space_x);
			tail_q  <= OUT_W'(tail_x);
			count_q <= OUT_W'(held_x);
			rok_q   <= ctl.peek_emit ? 1'b1 : ok_q;
			pbyte_q <= ctl.peek_emit ? ram_rdata : '0;
			last_q  <= ctl.peek_emit ? peek_last : 1'b1;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp_write_space = space_q;
	assign rsp_tail_data   = tail_q;
	assign rsp_data_count  = count_q;
	assign rsp_ok          = rok_q;
	assign rsp_peek_byte   = pbyte_q;
	assign rsp_last        = last_q;
endmodule

@@ hw/rtl/byte_ring_buffer_unit.sv @@
// top level of the byte ring buffer: controller, datapath and channel wiring
// status, commit, release and unused modes pass through the execute and emit states; the
//   result is registered once the result slot is free, and the next command is then taken
// byte store: offset reduced modulo the size by the remainder unit (one offset bit per cycle)
// peek of n bytes: one byte per cycle while results are taken
// reset: indices and count cleared, size 4096; store contents undefined, no clearing pass
module byte_ring_buffer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [brb_pkg::CFG_W-1:0]  cfg_wr_data,
	brb_cmd_if.sink                    cmd,
	brb_rsp_if.source                  rsp
);
	import brb_pkg::*;

	// command and status between the two halves
	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// controller sequences one command at a time
	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// datapath holds the indices, the byte store and the result register,
	// so a finished result can wait while the next command is taken
	brb_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.cmd_mode        (cmd.mode),
		.cmd_length      (cmd.length),
		.cmd_offset      (cmd.offset),
		.cmd_data_byte   (cmd.data_byte),
		.ctl             (ctl),
		.stat            (stat),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_write_space (rsp.write_space),
		.rsp_tail_data   (rsp.tail_data),
		.rsp_data_count  (rsp.data_count),
		.rsp_ok          (rsp.ok),
		.rsp_peek_byte   (rsp.peek_byte),
		.rsp_last        (rsp.last)
	);
endmodule

@@ verif/tb.sv @@
// self-checking testbench of the byte ring buffer unit
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brb_pkg::*;

	// unused operation codes, all answered with a refusal
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_W'(5);
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = MODE_W'(7);

	// quiet cycles before the run is declared hung
	localparam int HANG_LIMIT   = 4000;
	// length of the deliberate back-pressure stretch on the result side
	localparam int LONG_STALL   = 300;
	// settling time after the last result
	localparam int SETTLE       = 20;
	// items per random phase
	localparam int PHASE_ITEMS  = 140;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [LEN_W-1:0]  length;
		logic [OFF_W-1:0]  offset;
		logic [DATA_W-1:0] data_byte;
	} ring_cmd_t;

	typedef struct packed {
		logic [OUT_W-1:0]  write_space;
		logic [OUT_W-1:0]  tail_data;
		logic [OUT_W-1:0]  data_count;
		logic              ok;
		logic [DATA_W-1:0] peek_byte;
		logic              last;
	} ring_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CFG_W-1:0]  cfg_wr_data;

	brb_cmd_if cmd_if ();
	brb_rsp_if rsp_if ();

	byte_ring_buffer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_if),
		.rsp         (rsp_if)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// shadow of the ring: indices, count, size and byte contents
	// ring_written marks bytes that hold a known value, so peeks never
	// touch an entry that was never stored
	// ---------------------------------------------------------------
	int               ring_rd   = 0;
	int               ring_wr   = 0;
	int               ring_held = 0;
	int               ring_size = SIZE_RST;
	logic [DATA_W-1:0] ring_mem [0:BUF_DEPTH-1];
	bit               ring_written [0:BUF_DEPTH-1];

	// commands waiting for the driver, in issue order
	ring_cmd_t    pending_cmds[$];
	// results worked out at issue time, and how many each command gives
	ring_result_t predicted_results[$];
	int           results_per_cmd[$];
	// results owed by commands that the block has taken
	ring_result_t awaited_results[$];

	int fail_count     = 0;
	int issued         = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int stall_requests = 0;
	int stall_served   = 0;
	int stall_left     = 0;
	int quiet_cycles   = 0;

	int        drv_count;
	ring_cmd_t drv_item;
	ring_result_t mon_got;
	ring_result_t mon_want;

	// status fields as seen after an operation
	function automatic ring_result_t ring_status(bit ok, logic [DATA_W-1:0] pb, bit fin);
		ring_result_t r;
		int           space;
		bit           full;
		full = (ring_wr == ring_rd) && (ring_held > 0);
		if (ring_wr >= ring_rd)
			space = full ? 0 : ring_size - ring_wr;
		else
			space = (ring_rd - ring_wr <= 1) ? 0 : ring_rd - ring_wr - 1;
		r.write_space = OUT_W'(space);
		// wrapped or full data runs to the end of the store
		r.tail_data   = OUT_W'((ring_wr < ring_rd || full) ? ring_size - ring_rd : ring_held);
		r.data_count  = OUT_W'(ring_held);
		r.ok          = ok;
		r.peek_byte   = pb;
		r.last        = fin;
		return r;
	endfunction

	// advance the shadow by one command and queue the results it gives
	task automatic predict_command(ring_cmd_t c);
		int len;
		int addr;
		int n;
		len = int'(c.length);
		n   = 1;
		case (c.mode)
			MODE_STATUS: begin
				predicted_results.push_back(ring_status(1'b1, '0, 1'b1));
			end
			MODE_STORE: begin
				// offset may exceed the size, so the address wraps by remainder
				addr = (ring_wr + int'(c.offset)) % ring_size;
				ring_mem[addr]     = c.data_byte;
				ring_written[addr] = 1'b1;
				predicted_results.push_back(ring_status(1'b1, '0, 1'b1));
			end
			MODE_COMMIT: begin
				if (ring_held + len > ring_size || ring_wr + len > ring_size) begin
					predicted_results.push_back(ring_status(1'b0, '0, 1'b1));
				end else begin
					ring_wr   += len;
					ring_held += len;
					if (ring_wr == ring_size)
						ring_wr = 0;
					predicted_results.push_back(ring_status(1'b1, '0, 1'b1));
				end
			end
			MODE_RELEASE: begin
				if (len > ring_held) begin
					predicted_results.push_back(ring_status(1'b0, '0, 1'b1));
				end else begin
					ring_held -= len;
					ring_rd    = (ring_rd + len) % ring_size;
					predicted_results.push_back(ring_status(1'b1, '0, 1'b1));
				end
			end
			MODE_PEEK: begin
				if (len > MAX_PEEK || len > ring_held) begin
					predicted_results.push_back(ring_status(1'b0, '0, 1'b1));
				end else if (len == 0) begin
					predicted_results.push_back(ring_status(1'b1, '0, 1'b1));
				end else begin
					// one transaction per byte, wrapping at the end of the store
					for (int k = 0; k < len; k++)
						predicted_results.push_back(ring_status(1'b1,
							ring_mem[(ring_rd + k) % ring_size], k == len - 1));
					n = len;
				end
			end
			default: begin
				predicted_results.push_back(ring_status(1'b0, '0, 1'b1));
			end
		endcase
		results_per_cmd.push_back(n);
	endtask

	task automatic issue_command(logic [MODE_W-1:0] mode, int len, int off, int db);
		ring_cmd_t c;
		c.mode      = mode;
		c.length    = LEN_W'(len);
		c.offset    = OFF_W'(off);
		c.data_byte = DATA_W'(db);
		predict_command(c);
		pending_cmds.push_back(c);
		issued++;
	endtask

	// true when every byte of a peek of len bytes holds a stored value
	function automatic bit span_written(int len);
		for (int k = 0; k < len; k++)
			if (!ring_written[(ring_rd + k) % ring_size])
				return 1'b0;
		return 1'b1;
	endfunction

	// peek of a random length that only reads stored bytes
	task automatic issue_peek();
		int lim;
		int len;
		lim = (ring_held < MAX_PEEK) ? ring_held : MAX_PEEK;
		len = (lim == 0) ? 0 : $urandom_range(lim, 1);
		while (len > 0 && !span_written(len))
			len--;
		issue_command(MODE_PEEK, len, $urandom_range(OFF_W'('1)), $urandom_range(255));
	endtask

	// well-formed use: fill bytes, commit them, then peek and release some
	task automatic send_packet();
		ring_result_t now;
		int           n;
		now = ring_status(1'b1, '0, 1'b1);
		if (now.write_space == 0) begin
			issue_command(MODE_RELEASE, $urandom_range(ring_held, 1), 0, 0);
			return;
		end
		n = $urandom_range((now.write_space < 12) ? int'(now.write_space) : 12, 1);
		for (int k = 0; k < n; k++)
			issue_command(MODE_STORE, 0, k, $urandom_range(255));
		issue_command(MODE_COMMIT, n, 0, 0);
		if ($urandom_range(2) != 0)
			issue_peek();
		if ($urandom_range(1) != 0)
			issue_command(MODE_RELEASE, $urandom_range(ring_held, 1), 0, 0);
	endtask

	// anything the fields allow, mostly refused or out of order
	task automatic send_noise();
		ring_result_t now;
		int           len;
		now = ring_status(1'b1, '0, 1'b1);
		len = $urandom_range(8191);
		case ($urandom_range(7))
			0: issue_command(MODE_STATUS, len, $urandom_range(4095), $urandom_range(255));
			1: issue_command(MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)), len,
				$urandom_range(4095), $urandom_range(255));
			2: issue_command(MODE_STORE, len, $urandom_range(4095), $urandom_range(255));
			3: issue_command(MODE_COMMIT, len, $urandom_range(4095), $urandom_range(255));
			4: begin
				if (now.write_space != 0)
					issue_command(MODE_COMMIT, $urandom_range(int'(now.write_space), 1), 0, 0);
				else
					issue_command(MODE_STATUS, 0, 0, 0);
			end
			5: issue_command(MODE_RELEASE, len, $urandom_range(4095), $urandom_range(255));
			6: issue_command(MODE_RELEASE, $urandom_range(ring_held), 0, 0);
			default: begin
				if (len <= MAX_PEEK && len <= ring_held)
					issue_peek();
				else
					issue_command(MODE_PEEK, len, $urandom_range(4095), $urandom_range(255));
			end
		endcase
	endtask

	task automatic random_items(int count);
		int start;
		start = issued;
		while (issued - start < count) begin
			if ($urandom_range(9) < 7)
				send_packet();
			else
				send_noise();
		end
	endtask

	// hold back until every command is taken and every result is back
	task automatic wait_quiet();
		while (pending_cmds.size() != 0 || results_per_cmd.size() != 0
				|| awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// size write, only with the block idle; it also empties the ring
	task automatic write_size(int value);
		wait_quiet();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CFG_W'(value);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		ring_size = (value < 1) ? 1 : (value > BUF_DEPTH) ? BUF_DEPTH : value;
		ring_rd   = 0;
		ring_wr   = 0;
		ring_held = 0;
	endtask

	function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	// ---------------------------------------------------------------
	// command driver: a new transaction is offered only once the last
	// one has gone, so valid never drops while the block stalls
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
		end else begin
			if (cmd_if.valid && cmd_if.ready) begin
				// command taken: its results become due
				drv_count = results_per_cmd.pop_front();
				repeat (drv_count)
					awaited_results.push_back(predicted_results.pop_front());
			end
			if (!cmd_if.valid || cmd_if.ready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_item = pending_cmds.pop_front();
					cmd_if.valid     <= 1'b1;
					cmd_if.mode      <= drv_item.mode;
					cmd_if.length    <= drv_item.length;
					cmd_if.offset    <= drv_item.offset;
					cmd_if.data_byte <= drv_item.data_byte;
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor: checks each transaction against the oldest
	// expectation and drives ready, with random gaps and long holds
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				mon_got.write_space = rsp_if.write_space;
				mon_got.tail_data   = rsp_if.tail_data;
				mon_got.data_count  = rsp_if.data_count;
				mon_got.ok          = rsp_if.ok;
				mon_got.peek_byte   = rsp_if.peek_byte;
				mon_got.last        = rsp_if.last;
				if (awaited_results.size() == 0) begin
					$error("result transaction with nothing outstanding");
					fail_count++;
				end else begin
					mon_want = awaited_results.pop_front();
					check_field("write_space", mon_want.write_space, mon_got.write_space);
					check_field("tail_data", mon_want.tail_data, mon_got.tail_data);
					check_field("data_count", mon_want.data_count, mon_got.data_count);
					check_field("ok", mon_want.ok, mon_got.ok);
					check_field("peek_byte", mon_want.peek_byte, mon_got.peek_byte);
					check_field("last", mon_want.last, mon_got.last);
				end
			end
			// a long hold lets the block back up and stall its command side
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (stall_served != stall_requests) begin
				stall_served++;
				stall_left = LONG_STALL;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// hang detection: too long without any transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("byte_ring_buffer_unit verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// stimulus: directed corner cases, then three random phases with
	// different idle patterns and sizes
	// ---------------------------------------------------------------
	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		cmd_if.valid     = 1'b0;
		cmd_if.mode      = '0;
		cmd_if.length    = '0;
		cmd_if.offset    = '0;
		cmd_if.data_byte = '0;
		rsp_if.ready     = 1'b0;
		repeat (6) @(posedge clk);
		arst_n        <= 1'b1;
		send_idle_pct <= 27;
		recv_idle_pct <= 72;

		// empty ring at the size after reset
		issue_command(MODE_STATUS, 0, 0, 0);
		issue_command(MODE_SPARE_LO, 0, 0, 0);
		issue_command(MODE_SPARE_HI, 0, 0, 0);
		issue_command(MODE_RELEASE, 1, 0, 0);
		issue_command(MODE_PEEK, 0, 0, 0);
		issue_command(MODE_PEEK, 1, 0, 0);
		// extreme offsets and data, then fill the whole store in one commit
		issue_command(MODE_STORE, 0, 4095, 255);
		issue_command(MODE_STORE, 0, 0, 0);
		issue_command(MODE_COMMIT, BUF_DEPTH, 0, 0);
		issue_command(MODE_COMMIT, 1, 0, 0);
		issue_command(MODE_PEEK, MAX_PEEK + 1, 0, 0);
		issue_command(MODE_PEEK, 1, 0, 0);
		issue_command(MODE_RELEASE, BUF_DEPTH - 1, 0, 0);
		issue_command(MODE_PEEK, 1, 0, 0);
		issue_command(MODE_RELEASE, 2, 0, 0);
		// read index wraps back to the start
		issue_command(MODE_RELEASE, 1, 0, 0);
		issue_command(MODE_COMMIT, 8191, 0, 0);

		// size zero behaves as a single byte
		write_size(0);
		issue_command(MODE_STORE, 0, 4095, 8'h5A);
		issue_command(MODE_COMMIT, 1, 0, 0);
		issue_command(MODE_PEEK, 1, 0, 0);
		issue_command(MODE_COMMIT, 1, 0, 0);
		issue_command(MODE_RELEASE, 1, 0, 0);

		// five-byte ring: commit refused by the end of the store, then a
		// full ring peeked across the wrap
		write_size(5);
		for (int k = 0; k < 5; k++)
			issue_command(MODE_STORE, 0, k, $urandom_range(255));
		issue_command(MODE_COMMIT, 3, 0, 0);
		issue_command(MODE_RELEASE, 2, 0, 0);
		issue_command(MODE_COMMIT, 3, 0, 0);
		issue_command(MODE_COMMIT, 2, 0, 0);
		issue_command(MODE_COMMIT, 2, 0, 0);
		issue_command(MODE_PEEK, 5, 0, 0);
		issue_command(MODE_STATUS, 0, 0, 0);

		// small ring, slow consumer side
		write_size($urandom_range(40, 2));
		random_items(PHASE_ITEMS / 2);
		stall_requests <= stall_requests + 1;
		random_items(PHASE_ITEMS / 2);

		// oversize write behaves as the full store, slow producer side
		write_size(8191);
		send_idle_pct <= 72;
		recv_idle_pct <= 27;
		random_items(PHASE_ITEMS / 2);
		stall_requests <= stall_requests + 1;
		random_items(PHASE_ITEMS / 2);

		// medium ring at full rate
		write_size($urandom_range(300, 41));
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		random_items(PHASE_ITEMS);

		wait_quiet();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("byte_ring_buffer_unit verification clean");
		else
			$display("byte_ring_buffer_unit verification failed");
		$finish;
	end

endmodule

@@ byte_ring_buffer_unit.f @@
hw/rtl/brb_pkg.sv
hw/rtl/brb_cmd_if.sv
hw/rtl/brb_rsp_if.sv
hw/rtl/brb_ram.sv
hw/rtl/brb_ctrl.sv
hw/rtl/brb_dpath.sv
hw/rtl/byte_ring_buffer_unit.sv
verif/tb.sv
